FILE: sv/cfpsc_pkg.sv
package cfpsc_pkg;

	// command codes
	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_PUSH   = 2'd1,
		CMD_DECODE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// result status codes
	localparam logic [1:0] ST_NONE   = 2'd0;
	localparam logic [1:0] ST_WRITE  = 2'd1;
	localparam logic [1:0] ST_FILLED = 2'd2;

	localparam logic [1:0]  TYPE_IGNORED = 2'd3;
	localparam logic [14:0] PRI_NONE     = 15'h7FFF;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_SHIFT,
		S_HEX,
		S_OUT
	} state_t;

	// one nibble to uppercase ASCII hex
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'hA) r = 8'h30 + {4'd0, nib};
		else r = 8'h41 + {4'd0, nib} - 8'h0A;
		return r;
	endfunction

endpackage

FILE: sv/can_frame_priority_slot_capture.sv
// CAN route table and frame queue. Load, push and clear are each taken in the
// idle state, and input is ready again on the next cycle. A decode walks the
// queued frames in order against the table rows, one row compare per cycle on a
// single shared id comparator. Each frame's walk ends at its first matching row,
// or at the last row when nothing matches. After the scan comes the pick state.
// With no frame chosen, or an empty queue, the output state follows directly.
// Otherwise the shift state closes up the queue, moving down each entry behind
// the chosen one and running at least once. Eight hex steps follow, each making
// one character of each half when the status is write, then the output state.
// A decode holds input off until it leaves its output state. The result sits in
// its own output register, so loads, pushes and clears are taken while it waits.
// Only a decode reaching its output state stalls there until the previous word
// has left. The queue needs no clearing; the route table resets through per-row
// loaded bits.
module can_frame_priority_slot_capture #(
	parameter int TABLE_ROWS  = 32,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command[1:0], row_index[6:2], can_id[35:7], frame_data[99:36],
	// slot_offset[105:100], slot_mask[169:106], route_type[171:170],
	// priority_value[186:172], zero fill to 191
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], out_packet_type[3:2], out_slot[9:4], hex_first[73:10],
	// hex_second[137:74], filled_marks[201:138], zero fill to 207
	output logic [207:0] m_tdata
);
	localparam int RW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// input fields
	logic [1:0]  in_cmd;
	logic [4:0]  in_row;
	logic [28:0] in_id;
	logic [63:0] in_data;
	logic [5:0]  in_slot;
	logic [63:0] in_mask;
	logic [1:0]  in_type;
	logic [14:0] in_pri;
	assign in_cmd  = s_tdata[1:0];
	assign in_row  = s_tdata[6:2];
	assign in_id   = s_tdata[35:7];
	assign in_data = s_tdata[99:36];
	assign in_slot = s_tdata[105:100];
	assign in_mask = s_tdata[169:106];
	assign in_type = s_tdata[171:170];
	assign in_pri  = s_tdata[186:172];

	// storage
	logic [28:0] route_id_q   [TABLE_ROWS];
	logic [5:0]  route_slot_q [TABLE_ROWS];
	logic [63:0] route_mask_q [TABLE_ROWS];
	logic [1:0]  route_type_q [TABLE_ROWS];
	logic [14:0] route_pri_q  [TABLE_ROWS];
	logic [TABLE_ROWS-1:0] route_loaded_q;
	logic [28:0] queue_id_q   [QUEUE_DEPTH];
	logic [63:0] queue_data_q [QUEUE_DEPTH];
	logic [CW-1:0] count_q;
	logic [63:0] filled_q [3];

	cfpsc_pkg::state_t state_q, state_d;
	logic [QW-1:0] q_idx_q, best_q_q;
	logic [RW-1:0] r_idx_q, best_row_q;
	logic [14:0]   best_pri_q;
	logic          found_q;
	logic [63:0]   frame_q;
	logic [2:0]    hex_idx_q;
	logic [63:0]   hex1_q, hex2_q;
	logic [1:0]    o_status_q, o_type_q;
	logic [5:0]    o_slot_q;
	logic [63:0]   o_marks_q;
	logic [201:0]  res_q;
	logic          m_valid_q;

	logic in_acc, row_hit, q_last, r_last, row_ok, mark_clear, out_go;
	logic [1:0] t_sel;
	logic [63:0] cur_marks;

	assign s_tready = (state_q == cfpsc_pkg::S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, res_q};
	assign out_go   = !m_valid_q || m_tready;

	// shared id compare
	assign row_hit = route_loaded_q[r_idx_q] &&
		(route_id_q[r_idx_q] == queue_id_q[q_idx_q]);
	assign r_last  = (int'(r_idx_q) == TABLE_ROWS - 1);
	assign q_last  = ({{(32-CW){1'b0}}, count_q} == 32'(q_idx_q) + 32'd1);
	assign row_ok  = row_hit && (route_pri_q[r_idx_q] < best_pri_q);
	assign t_sel   = route_type_q[best_row_q];
	assign cur_marks = (t_sel == cfpsc_pkg::TYPE_IGNORED) ? 64'd0 :
		filled_q[t_sel[1] ? 2 : t_sel[0] ? 1 : 0];
	assign mark_clear = (cur_marks & route_mask_q[best_row_q]) == 64'd0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfpsc_pkg::S_IDLE: begin
				if (in_acc && in_cmd == cfpsc_pkg::CMD_DECODE)
					state_d = (count_q == '0) ? cfpsc_pkg::S_PICK : cfpsc_pkg::S_SCAN;
			end
			cfpsc_pkg::S_SCAN: begin
				if ((row_hit || r_last) && q_last) state_d = cfpsc_pkg::S_PICK;
			end
			cfpsc_pkg::S_PICK: state_d = found_q ? cfpsc_pkg::S_SHIFT : cfpsc_pkg::S_OUT;
			cfpsc_pkg::S_SHIFT: begin
				if ({{(32-QW){1'b0}}, q_idx_q} + 32'd1 >= {{(32-CW){1'b0}}, count_q})
					state_d = cfpsc_pkg::S_HEX;
			end
			cfpsc_pkg::S_HEX: if (hex_idx_q == 3'd7) state_d = cfpsc_pkg::S_OUT;
			cfpsc_pkg::S_OUT: if (out_go) state_d = cfpsc_pkg::S_IDLE;
			default: state_d = cfpsc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cfpsc_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_loaded_q <= '0;
			count_q <= '0;
			filled_q[0] <= '0;
			filled_q[1] <= '0;
			filled_q[2] <= '0;
			m_valid_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			// result word handshake
			if (state_q == cfpsc_pkg::S_OUT && out_go) m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				cfpsc_pkg::S_IDLE: begin
					found_q <= 1'b0;
					if (in_acc) begin
						if (in_cmd == cfpsc_pkg::CMD_LOAD && 32'(in_row) < TABLE_ROWS)
							route_loaded_q[RW'(in_row)] <= 1'b1;
						if (in_cmd == cfpsc_pkg::CMD_PUSH && 32'(count_q) < QUEUE_DEPTH)
							count_q <= count_q + CW'(1);
						if (in_cmd == cfpsc_pkg::CMD_CLEAR && in_type != cfpsc_pkg::TYPE_IGNORED)
							filled_q[in_type] <= '0;
					end
				end
				cfpsc_pkg::S_SCAN: if (row_ok) found_q <= 1'b1;
				cfpsc_pkg::S_PICK: begin
					if (found_q) begin
						count_q <= count_q - CW'(1);
						if (t_sel != cfpsc_pkg::TYPE_IGNORED && mark_clear)
							filled_q[t_sel] <= cur_marks | route_mask_q[best_row_q];
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			cfpsc_pkg::S_IDLE: begin
				q_idx_q <= '0;
				r_idx_q <= '0;
				best_pri_q <= cfpsc_pkg::PRI_NONE;
				best_q_q <= '0;
				best_row_q <= '0;
				hex_idx_q <= '0;
				hex1_q <= '0;
				hex2_q <= '0;
				if (in_acc && in_cmd == cfpsc_pkg::CMD_LOAD && 32'(in_row) < TABLE_ROWS) begin
					route_id_q[RW'(in_row)]   <= in_id;
					route_slot_q[RW'(in_row)] <= in_slot;
					route_mask_q[RW'(in_row)] <= in_mask;
					route_type_q[RW'(in_row)] <= in_type;
					route_pri_q[RW'(in_row)]  <= in_pri;
				end
				if (in_acc && in_cmd == cfpsc_pkg::CMD_PUSH && 32'(count_q) < QUEUE_DEPTH) begin
					queue_id_q[QW'(count_q)]   <= in_id;
					queue_data_q[QW'(count_q)] <= in_data;
				end
			end
			cfpsc_pkg::S_SCAN: begin
				if (row_ok) begin
					best_pri_q <= route_pri_q[r_idx_q];
					best_row_q <= r_idx_q;
					best_q_q   <= q_idx_q;
				end
				if (row_hit || r_last) begin
					r_idx_q <= '0;
					q_idx_q <= q_idx_q + QW'(1);
				end else begin
					r_idx_q <= r_idx_q + RW'(1);
				end
			end
			cfpsc_pkg::S_PICK: begin
				frame_q <= queue_data_q[best_q_q];
				q_idx_q <= best_q_q;
				o_type_q <= found_q ? t_sel : 2'd0;
				o_slot_q <= found_q ? route_slot_q[best_row_q] : 6'd0;
				if (!found_q) begin
					o_status_q <= cfpsc_pkg::ST_NONE;
					o_marks_q <= '0;
				end else if (t_sel == cfpsc_pkg::TYPE_IGNORED) begin
					o_status_q <= cfpsc_pkg::ST_FILLED;
					o_marks_q <= '0;
				end else if (mark_clear) begin
					o_status_q <= cfpsc_pkg::ST_WRITE;
					o_marks_q <= cur_marks | route_mask_q[best_row_q];
				end else begin
					o_status_q <= cfpsc_pkg::ST_FILLED;
					o_marks_q <= cur_marks;
				end
			end
			cfpsc_pkg::S_SHIFT: begin
				// count already decremented: move entries above the removed one down
				if ({{(32-QW){1'b0}}, q_idx_q} < {{(32-CW){1'b0}}, count_q}) begin
					queue_id_q[q_idx_q]   <= queue_id_q[QW'(32'(q_idx_q) + 1)];
					queue_data_q[q_idx_q] <= queue_data_q[QW'(32'(q_idx_q) + 1)];
				end
				q_idx_q <= q_idx_q + QW'(1);
			end
			cfpsc_pkg::S_HEX: begin
				// one character of each half per cycle when the status is write
				if (o_status_q == cfpsc_pkg::ST_WRITE) begin
					hex1_q <= {hex1_q[55:0], cfpsc_pkg::hex_char(frame_q[63:60])};
					hex2_q <= {hex2_q[55:0], cfpsc_pkg::hex_char(frame_q[31:28])};
				end
				frame_q <= {frame_q[59:32], 4'd0, frame_q[27:0], 4'd0};
				hex_idx_q <= hex_idx_q + 3'd1;
			end
			cfpsc_pkg::S_OUT: begin
				// capture the word once the output register is free
				if (out_go)
					res_q <= {o_marks_q, hex2_q, hex1_q, o_slot_q, o_type_q, o_status_q};
			end
			default: ;
		endcase
	end

endmodule
